>>> rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly table package
// Shared item types, command and status codes, and default sizes.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam int DEF_SLOT_COUNT = 8;
    localparam int DEF_SLOT_BYTES = 4096;
    localparam int DEF_MAX_ENTRY  = 64;

    // Widest slot index and store offset over the supported parameter ranges.
    localparam int MAX_SLOT_W = 6;
    localparam int MAX_OFF_W  = 16;

    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic [6:0] ENTRY_SIZE_RESET = 7'd64;

    localparam logic [1:0] CMD_ENTRY   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;

    localparam logic [2:0] ST_TAKEN    = 3'd0;
    localparam logic [2:0] ST_NOT_FRAG = 3'd1;
    localparam logic [2:0] ST_PENDING  = 3'd2;
    localparam logic [2:0] ST_DROPPED  = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_NO_SLOT  = 3'd5;
    localparam logic [2:0] ST_CMD_DONE = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  entry_byte;
        logic        entry_first;
        logic [2:0]  slot_select;
        logic [11:0] read_offset;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  done_slot;
        logic [14:0] done_id;
        logic [12:0] done_length;
        logic [7:0]  read_data;
    } t_result;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // Work handed from the classifier to the store side.
    typedef struct packed {
        t_op                   op;
        logic [MAX_SLOT_W-1:0] slot;
        logic [MAX_OFF_W-1:0]  offset;
        logic [7:0]            data;
        t_result               res;
    } t_job;

endpackage

>>> rtl/frt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write or read port, registered read data.
// ----------------------------------------------------------------------------
module frt_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/frt_fifo.sv
// ----------------------------------------------------------------------------
// Small register queue
// Any depth, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module frt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_buf[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/frt_front.sv
// ----------------------------------------------------------------------------
// Reassembly classifier
// Tracks entry position, decodes headers, owns the slot table, emits jobs.
// ----------------------------------------------------------------------------
module frt_front import frt_pkg::*; #(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int SLOT_BYTES = DEF_SLOT_BYTES,
    parameter int MAX_ENTRY  = DEF_MAX_ENTRY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    input  logic       i_accept,
    input  t_item      i_item,
    output t_job       o_job
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW = $clog2(MAX_ENTRY + 1);

    logic [6:0]            r_entry_size;
    logic [SLOT_COUNT-1:0] r_busy, n_busy, r_held, n_held;
    logic [14:0]           r_id  [SLOT_COUNT];
    logic [7:0]            r_tot [SLOT_COUNT];
    logic [7:0]            r_cnt [SLOT_COUNT];
    logic [23:0]           r_hdr, n_hdr;
    logic [PW-1:0]         r_pos, n_pos;
    logic                  r_verdict, n_verdict;
    logic [SW-1:0]         r_cur, n_cur;
    logic [7:0]            r_part, n_part;

    logic [PW-1:0]         es, payload, pos_eff;
    logic                  verd_eff;
    logic [14:0]           hid;
    logic [7:0]            htot, hidx;
    logic [SLOT_COUNT-1:0] mism;
    logic                  hit, free_any;
    logic [SW-1:0]         hit_idx, free_idx, sel_idx;
    logic [PW+7:0]         hdr_prod, len_prod;
    logic [PW+8:0]         st_addr;
    logic [7:0]            tot_cur, cnt_cur;
    logic                  tbl_we, cnt_we;
    logic [SW-1:0]         tbl_idx, cnt_idx;
    logic [7:0]            cnt_val;
    logic [31:0]           sel32;

    function automatic logic [2:0] slot3(input logic [SW-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[2:0];
    endfunction

    // Effective entry size, saturated to the supported range.
    always_comb begin
        if (r_entry_size < 7'd5) begin
            es = PW'(5);
        end else if (32'(r_entry_size) > MAX_ENTRY) begin
            es = PW'(MAX_ENTRY);
        end else begin
            es = PW'(r_entry_size);
        end
    end

    assign payload  = es - PW'(4);
    assign pos_eff  = i_item.entry_first ? '0 : r_pos;
    assign verd_eff = i_item.entry_first ? 1'b0 : r_verdict;
    assign hid      = {i_item.entry_byte[6:0], r_hdr[23:16]};
    assign htot     = r_hdr[15:8];
    assign hidx     = r_hdr[7:0];
    assign tot_cur  = r_tot[r_cur];
    assign cnt_cur  = r_cnt[r_cur];
    assign hdr_prod = (PW+8)'(htot) * (PW+8)'(payload);
    assign len_prod = (PW+8)'(tot_cur) * (PW+8)'(payload);
    assign st_addr  = (PW+9)'(r_part) * (PW+9)'(payload) + (PW+9)'(pos_eff - PW'(4));
    assign sel32    = 32'(i_item.slot_select);
    assign sel_idx  = sel32[SW-1:0];

    // Parallel id match and free-slot search, lowest slot first.
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            mism[s] = (hidx >= r_tot[s]) || (r_tot[s] != htot);
            if (r_busy[s] && r_id[s] == hid) begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
            if (!r_busy[s] && !r_held[s]) begin
                free_any = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_verdict = r_verdict;
        n_hdr     = r_hdr;
        n_cur     = r_cur;
        n_part    = r_part;
        n_busy    = r_busy;
        n_held    = r_held;
        tbl_we    = 1'b0;
        tbl_idx   = free_idx;
        cnt_we    = 1'b0;
        cnt_idx   = r_cur;
        cnt_val   = cnt_cur + 8'd1;
        o_job     = '0;
        o_job.op  = OP_NONE;
        o_job.data = i_item.entry_byte;
        if (i_accept) begin
            unique case (i_item.command)
                CMD_ENTRY: begin
                    n_pos     = pos_eff;
                    n_verdict = verd_eff;
                    o_job.res.status = ST_TAKEN;
                    if (pos_eff < es) begin
                        n_pos = pos_eff + PW'(1);
                        if (pos_eff == PW'(0)) begin
                            n_hdr = {16'd0, i_item.entry_byte};
                        end else if (pos_eff == PW'(1)) begin
                            n_hdr[15:8] = i_item.entry_byte;
                        end else if (pos_eff == PW'(2)) begin
                            n_hdr[23:16] = i_item.entry_byte;
                        end else if (pos_eff == PW'(3)) begin
                            n_verdict = 1'b0;
                            if (!i_item.entry_byte[7]) begin
                                o_job.res.status = ST_NOT_FRAG;
                            end else begin
                                o_job.res.done_id = hid;
                                if (hit) begin
                                    o_job.res.done_slot = slot3(hit_idx);
                                    if (mism[hit_idx]) begin
                                        n_busy[hit_idx]  = 1'b0;
                                        o_job.res.status = ST_DROPPED;
                                    end else begin
                                        n_verdict = 1'b1;
                                        n_cur     = hit_idx;
                                        n_part    = hidx;
                                    end
                                end else if (hidx >= htot || 32'(hdr_prod) > SLOT_BYTES) begin
                                    o_job.res.status = ST_DROPPED;
                                end else if (free_any) begin
                                    n_busy[free_idx] = 1'b1;
                                    tbl_we    = 1'b1;
                                    cnt_we    = 1'b1;
                                    cnt_idx   = free_idx;
                                    cnt_val   = 8'd0;
                                    n_verdict = 1'b1;
                                    n_cur     = free_idx;
                                    n_part    = hidx;
                                    o_job.res.done_slot = slot3(free_idx);
                                end else begin
                                    o_job.res.status = ST_NO_SLOT;
                                end
                            end
                        end else if (verd_eff && r_busy[r_cur]) begin
                            if (32'(st_addr) < SLOT_BYTES) begin
                                o_job.op     = OP_WRITE;
                                o_job.slot   = MAX_SLOT_W'(r_cur);
                                o_job.offset = MAX_OFF_W'(st_addr);
                            end
                            if ((PW+1)'(pos_eff) + (PW+1)'(1) == (PW+1)'(es)) begin
                                n_verdict = 1'b0;
                                cnt_we    = 1'b1;
                                o_job.res.done_slot   = slot3(r_cur);
                                o_job.res.done_id     = r_id[r_cur];
                                o_job.res.done_length = len_prod[12:0];
                                if (cnt_val == tot_cur) begin
                                    n_busy[r_cur]    = 1'b0;
                                    n_held[r_cur]    = 1'b1;
                                    o_job.res.status = ST_COMPLETE;
                                end else begin
                                    o_job.res.status = ST_PENDING;
                                end
                            end
                        end
                    end
                end
                CMD_READ, CMD_RELEASE: begin
                    o_job.res.status    = ST_CMD_DONE;
                    o_job.res.done_slot = i_item.slot_select;
                    if (sel32 < SLOT_COUNT) begin
                        if (i_item.command == CMD_READ) begin
                            if (32'(i_item.read_offset) < SLOT_BYTES) begin
                                o_job.op     = OP_READ;
                                o_job.slot   = MAX_SLOT_W'(sel_idx);
                                o_job.offset = MAX_OFF_W'(i_item.read_offset);
                            end
                        end else begin
                            n_held[sel_idx] = 1'b0;
                        end
                    end
                end
                CMD_SPARE: begin
                    o_job.res.status = ST_CMD_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_size <= ENTRY_SIZE_RESET;
            r_busy       <= '0;
            r_held       <= '0;
            r_hdr        <= '0;
            r_pos        <= '0;
            r_verdict    <= 1'b0;
            r_cur        <= '0;
            r_part       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_entry_size <= i_cfg_data;
            end
            r_busy    <= n_busy;
            r_held    <= n_held;
            r_hdr     <= n_hdr;
            r_pos     <= n_pos;
            r_verdict <= n_verdict;
            r_cur     <= n_cur;
            r_part    <= n_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_id[tbl_idx]  <= hid;
            r_tot[tbl_idx] <= htot;
        end
        if (cnt_we) begin
            r_cnt[cnt_idx] <= cnt_val;
        end
    end

endmodule

>>> rtl/frt_back.sv
// ----------------------------------------------------------------------------
// Reassembly store side
// Executes store writes and reads in order and queues the results.
// ----------------------------------------------------------------------------
module frt_back import frt_pkg::*; #(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_empty,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int AW    = $clog2(SLOT_BYTES);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    logic             issue;
    logic             r_inflight;
    logic             r_is_read;
    t_result          r_res, push_res;
    logic [7:0]       rdata;
    logic [CNT_W-1:0] res_cnt;
    logic             res_full;

    // Issue only when the result queue can still take everything in flight.
    assign issue     = !i_job_empty && (32'(res_cnt) + 32'(r_inflight) < RES_DEPTH);
    assign o_job_pop = issue;

    frt_ram #(
        .WIDTH  (8),
        .ADDR_W (SW + AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (issue && i_job.op == OP_WRITE),
        .i_addr  ({i_job.slot[SW-1:0], i_job.offset[AW-1:0]}),
        .i_wdata (i_job.data),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
        end else begin
            r_inflight <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_res     <= i_job.res;
            r_is_read <= (i_job.op == OP_READ);
        end
    end

    always_comb begin
        push_res = r_res;
        push_res.read_data = r_is_read ? rdata : 8'd0;
    end

    frt_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_inflight),
        .i_data  (push_res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty),
        .o_count (res_cnt)
    );

    // The issue credit keeps the queue from ever overflowing.
    logic unused_full;
    assign unused_full = res_full;

endmodule

>>> rtl/fragment_reassembly_table.sv
// Path: an accepted transaction passes through the job queue and the store
//   access into the result queue, where its result is shown.
// Throughput: one transaction per cycle while the job queue has room; the
//   message store takes one access per cycle while the result queue has room.
// Reset: synchronous, active low; clears slot state, entry position and
//   queues. The message store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Fragment reassembly table
// Reassembles fragmented link messages into per-slot byte stores.
// ----------------------------------------------------------------------------
module fragment_reassembly_table import frt_pkg::*; #(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int SLOT_BYTES = DEF_SLOT_BYTES,
    parameter int MAX_ENTRY  = DEF_MAX_ENTRY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_item      i_item,
    output logic       empty,
    input  logic       pop,
    output t_result    o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    // The front classifies each transaction as it is accepted: it tracks the
    // byte position within the current link entry, decodes the header on the
    // fourth byte against every slot in parallel, and updates the slot table
    // at once. What remains is a store write, a store read or nothing, and
    // that work travels with the finished result fields through a short job
    // queue, so that a store-side stall reaches the input only once it is full.

    t_job job_in, job_out;
    logic job_full, job_empty, job_pop, accept;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_cnt;

    assign accept      = push && !full;
    assign full        = job_full;
    // Configuration is to be changed only while idle (unchecked); always taken.
    assign o_cfg_ready = 1'b1;

    frt_front #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES),
        .MAX_ENTRY  (MAX_ENTRY)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_job      (job_in)
    );

    // Every accepted transaction yields exactly one job and one result.
    frt_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty),
        .o_count (job_cnt)
    );

    // The store side keeps job order, so a read always sees earlier writes.
    frt_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

    logic unused_cnt;
    assign unused_cnt = ^job_cnt;

endmodule

>>> rtl/frt_checker.sv
// ----------------------------------------------------------------------------
// Reassembly table checker
// Port-level properties of the reassembly table, bound to the top level.
// ----------------------------------------------------------------------------
module frt_checker import frt_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    // After reset no result may be shown.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.status <= ST_CMD_DONE)
        else $error("status code out of range");

    // Only command results may carry store data.
    a_data_only_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_CMD_DONE) |-> o_result.read_data == 8'd0)
        else $error("store data on a non-read result");

    a_cmd_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == ST_CMD_DONE)
            |-> (o_result.done_id == 15'd0 && o_result.done_length == 13'd0))
        else $error("id or length on a command result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

endmodule

bind fragment_reassembly_table frt_checker u_frt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
